/* design/rida_pkg.sv */
// Package for the region id block allocator: sizes, command codes, item and
// result types, and the width clamp and metaphysical shift helpers.
// No dependencies.
package rida_pkg;

   localparam int MIN_ID_BITS   = 18;
   localparam int MAX_ID_BITS   = 24;
   localparam int BLOCK_BITS    = MAX_ID_BITS - MIN_ID_BITS;
   localparam int NUM_BLOCKS    = 1 << BLOCK_BITS;
   localparam int LOG_LEN_BITS  = $clog2(BLOCK_BITS);
   localparam int IMPL_RESET    = 24;

   // field widths of the channels
   localparam int CMD_W   = 1;
   localparam int REQB_W  = 6;
   localparam int SID_W   = 24;
   localparam int EID_W   = 25;
   localparam int GB_W    = 5;
   localparam int SMETA_W = 23;
   localparam int EMETA_W = 24;
   localparam int IMPL_W  = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [REQB_W-1:0] request_bits;
      logic [SID_W-1:0]  free_start_id;
      logic [EID_W-1:0]  free_end_id;
   } item_type;

   typedef struct packed {
      logic               success;
      logic [GB_W-1:0]    granted_bits;
      logic [SID_W-1:0]   start_id;
      logic [EID_W-1:0]   end_id;
      logic [SMETA_W-1:0] start_meta_id;
      logic [EMETA_W-1:0] end_meta_id;
   } result_type;

   // top to engine
   typedef struct packed {
      logic start;
      logic take;
   } eng_ctl_type;

   // engine to top
   typedef struct packed {
      logic idle;
      logic done;
   } eng_status_type;

   // Zero selects the default width; then clamp to MIN .. MAX-1.
   function automatic logic [GB_W-1:0] clamp_bits(input logic [REQB_W-1:0] req);
      logic [GB_W-1:0] b;
      begin
         b = GB_W'(MIN_ID_BITS);
         if (req == '0) begin
            b = GB_W'(MIN_ID_BITS);
         end else if (req >= REQB_W'(MAX_ID_BITS)) begin
            b = GB_W'(MAX_ID_BITS - 1);
         end else if (req < REQB_W'(MIN_ID_BITS)) begin
            b = GB_W'(MIN_ID_BITS);
         end else begin
            b = req[GB_W-1:0];
         end
         return b;
      end
   endfunction

   // Metaphysical shift: MIN - (clamped implemented width - MIN).
   function automatic logic [IMPL_W-1:0] meta_shift(input logic [IMPL_W-1:0] impl);
      logic [IMPL_W-1:0] w;
      begin
         w = impl;
         if (w > IMPL_W'(MAX_ID_BITS)) begin
            w = IMPL_W'(MAX_ID_BITS);
         end
         if (w <= IMPL_W'(MIN_ID_BITS)) begin
            w = IMPL_W'(MIN_ID_BITS + 1);
         end
         return IMPL_W'(MIN_ID_BITS) - (w - IMPL_W'(MIN_ID_BITS));
      end
   endfunction

endpackage

/* design/rida_ifs.sv */
// Channel interfaces of the region id block allocator: request, response
// and register write. Depends on rida_pkg.
interface rida_req_if import rida_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [REQB_W-1:0] request_bits;
   logic [SID_W-1:0]  free_start_id;
   logic [EID_W-1:0]  free_end_id;

   modport source (output valid, command, request_bits, free_start_id, free_end_id,
                   input ready);
   modport sink   (input valid, command, request_bits, free_start_id, free_end_id,
                   output ready);
endinterface

interface rida_rsp_if import rida_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               success;
   logic [GB_W-1:0]    granted_bits;
   logic [SID_W-1:0]   start_id;
   logic [EID_W-1:0]   end_id;
   logic [SMETA_W-1:0] start_meta_id;
   logic [EMETA_W-1:0] end_meta_id;

   modport source (output valid, success, granted_bits, start_id, end_id,
                   start_meta_id, end_meta_id, input ready);
   modport sink   (input valid, success, granted_bits, start_id, end_id,
                   start_meta_id, end_meta_id, output ready);
endinterface

interface rida_csr_if import rida_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IMPL_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* design/rida_engine.sv */
// Used-map of region id blocks and the sequencer that scans, marks and
// clears it one block per cycle. Depends on rida_pkg.
module rida_engine
   import rida_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  eng_ctl_type       ctl,
   input  item_type          item,
   input  logic [IMPL_W-1:0] impl_bits,
   output eng_status_type    status,
   output result_type        result
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FREE,
      ST_SCAN,
      ST_MARK,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic                      used_mem [NUM_BLOCKS];
   logic                      used_rd_ff;
   logic                      wr_en;
   logic                      wr_val;
   logic [BLOCK_BITS:0]       k_ff, k_in;
   logic [BLOCK_BITS:0]       last_ff, last_in;
   logic [BLOCK_BITS-1:0]     pos_ff, pos_in;
   logic [LOG_LEN_BITS-1:0]   lg_ff, lg_in;
   logic [GB_W-1:0]           bits_ff, bits_in;
   logic                      ok_ff, ok_in;
   logic                      grant_ff, grant_in;

   logic [BLOCK_BITS:0]       len;
   logic [BLOCK_BITS:0]       run_end;
   logic [BLOCK_BITS:0]       next_pos;
   logic [GB_W-1:0]           req_clamped;
   logic [LOG_LEN_BITS-1:0]   req_lg;
   logic [BLOCK_BITS:0]       req_len;
   logic [BLOCK_BITS:0]       free_last;
   logic                      cur_used;
   logic [IMPL_W-1:0]         sh;

   assign len       = (BLOCK_BITS+1)'(1) << lg_ff;
   assign run_end   = (BLOCK_BITS+1)'(pos_ff) + len - (BLOCK_BITS+1)'(1);
   assign next_pos  = (BLOCK_BITS+1)'(pos_ff) + len;
   assign cur_used  = used_rd_ff;

   assign req_clamped = clamp_bits(item.request_bits);
   assign req_lg      = LOG_LEN_BITS'(req_clamped - GB_W'(MIN_ID_BITS));
   assign req_len     = (BLOCK_BITS+1)'(1) << req_lg;

   // clip the release range at the end of the map
   always_comb begin
      if (item.free_end_id[EID_W-1:MIN_ID_BITS] > (EID_W-MIN_ID_BITS)'(NUM_BLOCKS)) begin
         free_last = (BLOCK_BITS+1)'(NUM_BLOCKS);
      end else begin
         free_last = (BLOCK_BITS+1)'(item.free_end_id[EID_W-1:MIN_ID_BITS]);
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      last_in  = last_ff;
      pos_in   = pos_ff;
      lg_in    = lg_ff;
      bits_in  = bits_ff;
      ok_in    = ok_ff;
      grant_in = grant_ff;
      wr_en    = 1'b0;
      wr_val   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            // free one block per cycle after reset
            wr_en = 1'b1;
            if (k_ff == (BLOCK_BITS+1)'(NUM_BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + (BLOCK_BITS+1)'(1);
            end
         end
         ST_IDLE: begin
            if (ctl.start) begin
               grant_in = 1'b0;
               if (cmd_type'(item.command) == CMD_FREE) begin
                  ok_in   = 1'b1;
                  k_in    = (BLOCK_BITS+1)'(item.free_start_id[SID_W-1:MIN_ID_BITS]);
                  last_in = free_last;
                  if (item.request_bits == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_FREE;
                  end
               end else begin
                  ok_in    = 1'b0;
                  bits_in  = req_clamped;
                  lg_in    = req_lg;
                  pos_in   = req_len[BLOCK_BITS-1:0];
                  k_in     = req_len;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_FREE: begin
            if (k_ff < last_ff) begin
               wr_en = 1'b1;
               k_in  = k_ff + (BLOCK_BITS+1)'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (cur_used) begin
               // skip to the next aligned run
               if (next_pos >= (BLOCK_BITS+1)'(NUM_BLOCKS)) begin
                  state_in = ST_DONE;
               end else begin
                  pos_in = next_pos[BLOCK_BITS-1:0];
                  k_in   = next_pos;
               end
            end else if (k_ff == run_end) begin
               k_in     = (BLOCK_BITS+1)'(pos_ff);
               state_in = ST_MARK;
            end else begin
               k_in = k_ff + (BLOCK_BITS+1)'(1);
            end
         end
         ST_MARK: begin
            wr_en  = 1'b1;
            wr_val = 1'b1;
            if (k_ff == run_end) begin
               ok_in    = 1'b1;
               grant_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               k_in = k_ff + (BLOCK_BITS+1)'(1);
            end
         end
         ST_DONE: begin
            if (ctl.take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         k_ff     <= '0;
         ok_ff    <= 1'b0;
         grant_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         ok_ff    <= ok_in;
         grant_ff <= grant_in;
      end
      last_ff <= last_in;
      pos_ff  <= pos_in;
      lg_ff   <= lg_in;
      bits_ff <= bits_in;
   end

   // one block written and one read per cycle; the read follows the next
   // index so the registered bit belongs to k_ff
   always_ff @(posedge clock) begin
      if (wr_en) begin
         used_mem[k_ff[BLOCK_BITS-1:0]] <= wr_val;
      end
      used_rd_ff <= used_mem[k_in[BLOCK_BITS-1:0]];
   end

   assign sh = meta_shift(impl_bits);

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);

   always_comb begin
      result         = '0;
      result.success = ok_ff;
      if (grant_ff) begin
         result.granted_bits  = bits_ff;
         result.start_id      = {pos_ff, MIN_ID_BITS'(0)};
         result.end_id        = {next_pos, MIN_ID_BITS'(0)};
         result.start_meta_id = SMETA_W'(pos_ff) << sh;
         result.end_meta_id   = EMETA_W'((BLOCK_BITS+1)'(pos_ff) + (BLOCK_BITS+1)'(1)) << sh;
      end
   end

   // a run is only marked after the scan found every block of it free
   a_mark_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK |-> !cur_used)
      else $error("marking a block that is already used");

   a_scan_in_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (k_ff >= (BLOCK_BITS+1)'(pos_ff)) && (k_ff <= run_end))
      else $error("scan index left the candidate run");

   a_scan_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |->
         (((BLOCK_BITS+1)'(pos_ff) & (len - (BLOCK_BITS+1)'(1))) == '0) && (pos_ff != '0))
      else $error("candidate run misaligned or on reserved block");

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && grant_ff |-> ok_ff && (k_ff == run_end))
      else $error("grant reported without marked run");

endmodule

/* design/region_id_block_allocator.sv */
// Top level of the region id block allocator: channel handshakes, the
// implemented width register and the response register.
// Depends on rida_pkg, rida_ifs and rida_engine.
//
// Usage: the req channel carries allocate and free commands, the rsp channel
// returns one result per command, and the csr channel writes the implemented
// region id width (always ready, written on any transfer; write it only while
// no command is in flight). The map holds 64 blocks of 2^18 ids, block 0
// reserved.
// Sequence: a free releases the blocks of its range and then shows its result
// (none are released when the width is zero). An allocate runs the first-fit
// scan, marks the run that it finds, if any, and then shows its result. One
// command at a time: req ready is high only while the sequencer is idle, from
// the cycle after the previous result moved into the response register.
// After reset the map is cleared one block per cycle with req ready low, and the
// width resets to 24. A finished result sits in the response register; while
// the receiver stalls, the next command may be accepted and worked, and its
// result waits in the engine until the register frees.
module region_id_block_allocator
   import rida_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   rida_req_if.sink   req,
   rida_rsp_if.source rsp,
   rida_csr_if.sink   csr
);

   eng_ctl_type       ctl;
   eng_status_type    status;
   item_type          item;
   result_type        result;

   logic [IMPL_W-1:0] impl_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;

   assign item.command       = req.command;
   assign item.request_bits  = req.request_bits;
   assign item.free_start_id = req.free_start_id;
   assign item.free_end_id   = req.free_end_id;

   assign req.ready = status.idle;
   assign csr.ready = 1'b1;

   assign ctl.start = req.valid && status.idle;
   assign ctl.take  = status.done && (!rsp_valid_ff || rsp.ready);

   rida_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .item      (item),
      .impl_bits (impl_ff),
      .status    (status),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         impl_ff      <= IMPL_W'(IMPL_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            impl_ff <= csr.data;
         end
         if (ctl.take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (ctl.take) begin
         rsp_ff <= result;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.success       = rsp_ff.success;
   assign rsp.granted_bits  = rsp_ff.granted_bits;
   assign rsp.start_id      = rsp_ff.start_id;
   assign rsp.end_id        = rsp_ff.end_id;
   assign rsp.start_meta_id = rsp_ff.start_meta_id;
   assign rsp.end_meta_id   = rsp_ff.end_meta_id;

endmodule

/* sim/rida_allocation_checker.sv */
// Watches the request, response and register channels of the region id block
// allocator, predicts each response and compares it field by field.
// Depends on rida_pkg and the channel interfaces in rida_ifs.
module rida_allocation_checker
   import rida_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   rida_req_if        req,
   rida_rsp_if        rsp,
   rida_csr_if        csr,
   output int         fail_count,
   output int         pending,
   output int         granted,
   output int         refused
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [NUM_BLOCKS-1:0] block_taken;
   logic [IMPL_W-1:0]     impl_width;
   result_type            awaited_results [$];
   int                    rsp_seen;

   function automatic bit span_is_free(input int unsigned at, input int unsigned len);
      bit ok;
      ok = 1'b1;
      for (int unsigned k = at; k < at + len; k++) begin
         if (k >= NUM_BLOCKS || block_taken[k]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // Model one command against the used map and return its response.
   function automatic result_type predict_outcome(input item_type cmd);
      result_type  res;
      int unsigned width;
      int unsigned run_len;
      int unsigned pos;
      int unsigned impl;
      int unsigned shift;
      int unsigned first_blk;
      int unsigned stop_blk;
      res = '0;
      if (cmd_type'(cmd.command) == CMD_FREE) begin
         first_blk = cmd.free_start_id >> MIN_ID_BITS;
         stop_blk  = cmd.free_end_id >> MIN_ID_BITS;
         if (stop_blk > NUM_BLOCKS) begin
            stop_blk = NUM_BLOCKS;
         end
         if (cmd.request_bits != '0) begin
            for (int unsigned k = first_blk; k < stop_blk; k++) begin
               block_taken[k] = 1'b0;
            end
         end
         res.success = 1'b1;
         return res;
      end

      width = cmd.request_bits;
      if (width == 0) begin
         width = MIN_ID_BITS;
      end
      if (width >= MAX_ID_BITS) begin
         width = MAX_ID_BITS - 1;
      end
      if (width < MIN_ID_BITS) begin
         width = MIN_ID_BITS;
      end
      run_len = 1 << (width - MIN_ID_BITS);

      // first fit over aligned positions, block 0 never offered
      pos = run_len;
      while (pos < NUM_BLOCKS && !span_is_free(pos, run_len)) begin
         pos += run_len;
      end
      if (pos >= NUM_BLOCKS) begin
         refused++;
         return res;
      end
      for (int unsigned k = pos; k < pos + run_len; k++) begin
         block_taken[k] = 1'b1;
      end
      granted++;

      impl = impl_width;
      if (impl > MAX_ID_BITS) begin
         impl = MAX_ID_BITS;
      end
      if (impl <= MIN_ID_BITS) begin
         impl = MIN_ID_BITS + 1;
      end
      shift = MIN_ID_BITS - (impl - MIN_ID_BITS);

      res.success       = 1'b1;
      res.granted_bits  = GB_W'(width);
      res.start_id      = SID_W'(pos << MIN_ID_BITS);
      res.end_id        = EID_W'((pos + run_len) << MIN_ID_BITS);
      res.start_meta_id = SMETA_W'(pos << shift);
      res.end_meta_id   = EMETA_W'((pos + 1) << shift);
      return res;
   endfunction

   task automatic note_mismatch(input string what, input longint unsigned got,
                                input longint unsigned want);
      if (fail_count < 40) begin
         $display("[%0t] response %0d, %s: got 0x%0h, expected 0x%0h",
                  $realtime, rsp_seen, what, got, want);
      end
      fail_count++;
   endtask

   task automatic compare_result(input result_type got, input result_type want);
      if (got.success !== want.success) begin
         note_mismatch("success", got.success, want.success);
      end
      if (got.granted_bits !== want.granted_bits) begin
         note_mismatch("granted_bits", got.granted_bits, want.granted_bits);
      end
      if (got.start_id !== want.start_id) begin
         note_mismatch("start_id", got.start_id, want.start_id);
      end
      if (got.end_id !== want.end_id) begin
         note_mismatch("end_id", got.end_id, want.end_id);
      end
      if (got.start_meta_id !== want.start_meta_id) begin
         note_mismatch("start_meta_id", got.start_meta_id, want.start_meta_id);
      end
      if (got.end_meta_id !== want.end_meta_id) begin
         note_mismatch("end_meta_id", got.end_meta_id, want.end_meta_id);
      end
   endtask

   always @(posedge clock) begin : watch
      result_type got;
      item_type   cmd;
      if (reset) begin
         block_taken = '0;
         impl_width  = IMPL_W'(IMPL_RESET);
         awaited_results.delete();
         fail_count  = 0;
         pending     = 0;
         granted     = 0;
         refused     = 0;
         rsp_seen    = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            impl_width = csr.data;
         end
         if (rsp.valid && rsp.ready) begin
            got.success       = rsp.success;
            got.granted_bits  = rsp.granted_bits;
            got.start_id      = rsp.start_id;
            got.end_id        = rsp.end_id;
            got.start_meta_id = rsp.start_meta_id;
            got.end_meta_id   = rsp.end_meta_id;
            if (awaited_results.size() == 0) begin
               note_mismatch("response with nothing outstanding", 0, 0);
            end else begin
               compare_result(got, awaited_results.pop_front());
            end
            rsp_seen++;
         end
         if (req.valid && req.ready) begin
            cmd.command       = req.command;
            cmd.request_bits  = req.request_bits;
            cmd.free_start_id = req.free_start_id;
            cmd.free_end_id   = req.free_end_id;
            awaited_results.push_back(predict_outcome(cmd));
         end
         pending = awaited_results.size();
      end
   end

endmodule

/* sim/tb_top.sv */
// Top of the region id block allocator testbench: clock, reset, command and
// width register stimulus, response back-pressure and the final verdict.
// Depends on rida_pkg, rida_ifs, region_id_block_allocator and rida_allocation_checker.
module tb_top;
   import rida_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PER_PHASE = 190;
   localparam int HOLD_OFF_CYCLES  = 800;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int PHASE_SETTLE     = 8;
   localparam int END_SETTLE       = 120;

   logic clock;
   logic reset;

   int fail_count;
   int pending;
   int granted;
   int refused;

   int n_alloc;
   int n_free;
   int n_settings;
   bit steady;
   bit hold_armed;
   int unsigned quiet_cycles;

   rida_req_if req_ch ();
   rida_rsp_if rsp_ch ();
   rida_csr_if csr_ch ();

   region_id_block_allocator i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   rida_allocation_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr        (csr_ch),
      .fail_count (fail_count),
      .pending    (pending),
      .granted    (granted),
      .refused    (refused)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic item_type alloc_cmd(input logic [REQB_W-1:0] bits);
      item_type it;
      it.command       = CMD_ALLOC;
      it.request_bits  = bits;
      it.free_start_id = SID_W'($urandom);
      it.free_end_id   = EID_W'($urandom);
      return it;
   endfunction

   function automatic item_type free_cmd(input logic [REQB_W-1:0] bits,
                                         input logic [SID_W-1:0] first_id,
                                         input logic [EID_W-1:0] stop_id);
      item_type it;
      it.command       = CMD_FREE;
      it.request_bits  = bits;
      it.free_start_id = first_id;
      it.free_end_id   = stop_id;
      return it;
   endfunction

   // Mostly allocations and aligned frees of grant-shaped ranges, some noise.
   function automatic item_type random_cmd();
      item_type    it;
      int unsigned r;
      int unsigned width;
      int unsigned len;
      int unsigned pos;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         r = $urandom_range(0, 9);
         if (r < 7) begin
            width = $urandom_range(18, 20);
         end else if (r < 8) begin
            width = $urandom_range(21, 23);
         end else begin
            width = $urandom_range(0, 63);
         end
         it = alloc_cmd(REQB_W'(width));
      end else if (r < 88) begin
         width = $urandom_range(18, 21);
         len   = 1 << (width - MIN_ID_BITS);
         pos   = $urandom_range(0, NUM_BLOCKS / len - 1) * len;
         it = free_cmd(REQB_W'(width), SID_W'(pos << MIN_ID_BITS),
                       EID_W'((pos + len) << MIN_ID_BITS));
         // low id bits inside a block are dropped by the block index
         if ($urandom_range(0, 1) == 1) begin
            it.free_start_id[MIN_ID_BITS-1:0] = MIN_ID_BITS'($urandom);
            it.free_end_id[MIN_ID_BITS-1:0]   = MIN_ID_BITS'($urandom);
         end
      end else begin
         it.command       = CMD_W'($urandom_range(0, 1));
         it.request_bits  = REQB_W'($urandom);
         it.free_start_id = SID_W'($urandom);
         it.free_end_id   = EID_W'($urandom);
      end
      return it;
   endfunction

   task automatic send_cmd(input item_type it);
      int unsigned gap;
      req_ch.valid         <= 1'b1;
      req_ch.command       <= it.command;
      req_ch.request_bits  <= it.request_bits;
      req_ch.free_start_id <= it.free_start_id;
      req_ch.free_end_id   <= it.free_end_id;
      do @(posedge clock); while (!req_ch.ready);
      if (cmd_type'(it.command) == CMD_ALLOC) begin
         n_alloc++;
      end else begin
         n_free++;
      end
      gap = pick_gap();
      // keep valid high for a back-to-back transfer
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_width(input logic [IMPL_W-1:0] w);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= w;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      n_settings++;
   endtask

   // Drop valid, wait out every outstanding response, then let the block settle.
   task automatic wait_drained(input int unsigned settle);
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // response side back-pressure
   initial begin
      int unsigned gap;
      rsp_ch.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_armed) begin
            hold_armed = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (steady) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            gap = pick_gap();
            if (gap != 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // end the run when no transfer of any kind happens for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] no transfer for %0d cycles", $realtime, quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [IMPL_W-1:0] width_plan [$];
      item_type          directed [$];
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.command       = CMD_ALLOC;
      req_ch.request_bits  = '0;
      req_ch.free_start_id = '0;
      req_ch.free_end_id   = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.data          = '0;
      steady               = 1'b0;
      hold_armed           = 1'b0;
      n_alloc              = 0;
      n_free               = 0;
      n_settings           = 0;
      quiet_cycles         = 0;

      // width register extremes, clamped values and one random setting
      width_plan = '{5'd0, 5'd31, 5'd19, 5'd24, 5'd18, 5'd21, 5'd22, 5'd20};
      width_plan.push_back(IMPL_W'($urandom_range(0, 31)));

      // every width class, clamps, exhaustion and the odd free ranges
      directed.push_back(alloc_cmd(6'd0));
      directed.push_back(alloc_cmd(6'd17));
      directed.push_back(alloc_cmd(6'd18));
      directed.push_back(alloc_cmd(6'd19));
      directed.push_back(alloc_cmd(6'd20));
      directed.push_back(alloc_cmd(6'd21));
      directed.push_back(alloc_cmd(6'd22));
      directed.push_back(alloc_cmd(6'd23));
      directed.push_back(alloc_cmd(6'd24));
      directed.push_back(alloc_cmd(6'd63));
      directed.push_back(free_cmd(6'd0, 24'h000000, 25'h1000000));
      directed.push_back(alloc_cmd(6'd1));
      directed.push_back(free_cmd(6'd23, 24'hFFFFFF, 25'h0000000));
      directed.push_back(free_cmd(6'd18, 24'h140000, 25'h0140000));
      directed.push_back(free_cmd(6'd63, 24'h000000, 25'h1FFFFFF));
      directed.push_back(alloc_cmd(6'd23));
      directed.push_back(alloc_cmd(6'd22));
      directed.push_back(alloc_cmd(6'd22));
      directed.push_back(alloc_cmd(6'd21));
      directed.push_back(free_cmd(6'd21, 24'h200000, 25'h0400000));
      directed.push_back(free_cmd(6'd1, 24'h000000, 25'h0080000));
      directed.push_back(alloc_cmd(6'd18));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_cmd(directed[i]);
      end
      wait_drained(PHASE_SETTLE);

      foreach (width_plan[p]) begin
         write_width(width_plan[p]);
         steady = (p == 3);
         // stall the receiver long enough to back the block up
         hold_armed = (p == 2);
         repeat (RANDOM_PER_PHASE) send_cmd(random_cmd());
         wait_drained(PHASE_SETTLE);
      end
      steady = 1'b0;
      wait_drained(END_SETTLE);

      $display("Sent %0d commands (%0d allocate, %0d free) under %0d width settings.",
               n_alloc + n_free, n_alloc, n_free, n_settings);
      $display("Grants %0d, refusals for lack of space %0d, mismatches %0d.",
               granted, refused, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
